FILE: src/cal_pkg.sv
`default_nettype none

package cal_pkg;

    // opcodes of an input event
    localparam logic [1:0] OP_TRY_ACCEPT  = 2'd0;
    localparam logic [1:0] OP_CHECK_ONLY  = 2'd1;
    localparam logic [1:0] OP_NOTE_ACCEPT = 2'd2;
    localparam logic [1:0] OP_NOTE_CLOSE  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INACTIVE = 2'd1;
    localparam logic [1:0] ST_CAP_HIT  = 2'd2;
    localparam logic [1:0] ST_RATE_HIT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_MAX_CONC = 2'd1;
    localparam logic [1:0] REG_RATE     = 2'd2;

    // field widths
    localparam int OP_W     = 2;
    localparam int TIME_W   = 48;
    localparam int SEC_W    = 39;
    localparam int CNT_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int LEVEL_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 192;

    // bucket scale: one token in fractional units
    localparam logic [15:0] UNITS_PER_TOKEN = 16'd60000;

    // ms to seconds: n / 1000 = (n >> 3) / 125, with the 45-bit dividend
    // split at bit 24 and 2^24 = 125 * 134217 + 91
    localparam int          DIV_SPLIT  = 24;
    localparam int          DIV_HI_W   = 21;
    localparam int          DIV_REM_W  = 29;
    localparam logic [17:0] DIV_HI_MUL = 18'd134217;
    localparam logic [6:0]  DIV_LO_MUL = 7'd91;
    // ceil(2^36 / 125), exact for a remainder below 2^29
    localparam logic [29:0] DIV_RECIP  = 30'd549755814;
    localparam int          DIV_PROD_W = 59;
    localparam int          DIV_SHIFT  = 36;
    localparam int          DIV_QLO_W  = DIV_PROD_W - DIV_SHIFT;

    // one event on its way from the front pipeline to the state stage
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now_ms;
        logic [SEC_W-1:0]  now_s;
    } t_event;

    function automatic logic [TOTAL_W-1:0] sat_inc32(input logic [TOTAL_W-1:0] v);
        sat_inc32 = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: src/cal_front.sv
`default_nettype none

// two-stage front pipeline: registers each event and converts its
// millisecond time stamp to seconds by reciprocal multiplication
module cal_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [cal_pkg::OP_W-1:0]         i_op,
    input  wire  [cal_pkg::TIME_W-1:0]       i_now_ms,
    output logic                             o_valid,
    input  wire                              i_ready,
    output cal_pkg::t_event                  o_event
);

    logic                                r_v1;
    logic [cal_pkg::OP_W-1:0]            r_op1;
    logic [cal_pkg::TIME_W-1:0]          r_now1;
    logic [cal_pkg::DIV_REM_W-1:0]       r_rem1;
    logic [cal_pkg::SEC_W-1:0]           r_qhi1;

    logic                                r_v2;
    logic [cal_pkg::OP_W-1:0]            r_op2;
    logic [cal_pkg::TIME_W-1:0]          r_now2;
    logic [cal_pkg::DIV_QLO_W-1:0]       r_qlo2;
    logic [cal_pkg::SEC_W-1:0]           r_qhi2;

    logic                                mv1;
    logic                                mv2;
    logic                                ld2_ok;
    logic                                ld1_ok;
    logic [cal_pkg::DIV_HI_W-1:0]        div_hi;
    logic [cal_pkg::DIV_SPLIT-1:0]       div_lo;
    logic [cal_pkg::DIV_REM_W-1:0]       n_rem1;
    logic [cal_pkg::SEC_W-1:0]           n_qhi1;
    logic [cal_pkg::DIV_PROD_W-1:0]      prod;

    // flow control: each stage moves when the next one is free
    assign mv2    = r_v2 & i_ready;
    assign ld2_ok = ~r_v2 | mv2;
    assign mv1    = r_v1 & ld2_ok;
    assign ld1_ok = ~r_v1 | mv1;
    assign o_ready = ld1_ok;

    // split the eighth of the time stamp into high and low parts
    assign div_hi = i_now_ms[cal_pkg::TIME_W-1 -: cal_pkg::DIV_HI_W];
    assign div_lo = i_now_ms[3 +: cal_pkg::DIV_SPLIT];
    assign n_rem1 = cal_pkg::DIV_REM_W'(div_hi) * cal_pkg::DIV_REM_W'(cal_pkg::DIV_LO_MUL)
                  + cal_pkg::DIV_REM_W'(div_lo);
    assign n_qhi1 = cal_pkg::SEC_W'(div_hi) * cal_pkg::SEC_W'(cal_pkg::DIV_HI_MUL);

    // remainder over 125 by reciprocal
    assign prod = cal_pkg::DIV_PROD_W'(r_rem1) * cal_pkg::DIV_PROD_W'(cal_pkg::DIV_RECIP);

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ld1_ok) begin
                r_v1 <= i_valid;
            end
            if (ld2_ok) begin
                r_v2 <= r_v1;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (ld1_ok && i_valid) begin
            r_op1  <= i_op;
            r_now1 <= i_now_ms;
            r_rem1 <= n_rem1;
            r_qhi1 <= n_qhi1;
        end
        if (mv1) begin
            r_op2  <= r_op1;
            r_now2 <= r_now1;
            r_qlo2 <= prod[cal_pkg::DIV_PROD_W-1:cal_pkg::DIV_SHIFT];
            r_qhi2 <= r_qhi1;
        end
    end

    assign o_valid        = r_v2;
    assign o_event.op     = r_op2;
    assign o_event.now_ms = r_now2;
    assign o_event.now_s  = r_qhi2 + cal_pkg::SEC_W'(r_qlo2);

endmodule

`default_nettype wire

FILE: src/connection_admission_limiter.sv
// path: an event passes the two front stages, then the state update into the output register
// throughput: one event per cycle unless the output is stalled; the state
//   update for one event is a read-modify-write, so back-to-back events see each other
// reset (synchronous, active low): all counters, the bucket, its stamp and
//   the configuration registers go to zero; pipeline and output are emptied
`default_nettype none

module connection_admission_limiter (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_s_tvalid,
    output logic                                   o_s_tready,
    // opcode[1:0], now_ms[49:2], zero pad[55:50]
    input  wire  [cal_pkg::IN_TDATA_W-1:0]         i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    // status[1:0], active_count[17:2], accepted_total[49:18],
    // cap_reject_total[81:50], rate_reject_total[113:82],
    // last_seen_s[152:114], tokens_scaled[184:153], zero pad[191:185]
    output logic [cal_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    input  wire                                    i_cfg_we,
    input  wire  [cal_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire  [cal_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int CW = cal_pkg::CNT_W;
    localparam int TW = cal_pkg::TOTAL_W;
    localparam int LW = cal_pkg::LEVEL_W;
    localparam int MW = cal_pkg::TIME_W;
    localparam int SW = cal_pkg::SEC_W;

    // configuration
    logic              r_enable;
    logic [CW-1:0]     r_max_conc;
    logic [CW-1:0]     r_rate;
    logic [LW-1:0]     r_cap;

    // credential state
    logic [CW-1:0]     r_open;
    logic [TW-1:0]     r_acc;
    logic [TW-1:0]     r_cap_rej;
    logic [TW-1:0]     r_rate_rej;
    logic [SW-1:0]     r_last_s;
    logic [LW-1:0]     r_level;
    logic [MW-1:0]     r_stamp;

    logic [CW-1:0]     n_open;
    logic [TW-1:0]     n_acc;
    logic [TW-1:0]     n_cap_rej;
    logic [TW-1:0]     n_rate_rej;
    logic [SW-1:0]     n_last_s;
    logic [LW-1:0]     n_level;
    logic [MW-1:0]     n_stamp;
    logic [1:0]        n_status;

    // output register
    logic              r_ov;
    logic [1:0]        r_status;

    logic              fe_valid;
    logic              out_free;
    logic              mv;
    cal_pkg::t_event   fe_event;

    logic [LW-1:0]     cfg_cap;
    logic [MW-1:0]     elapsed;
    logic [15:0]       el_clip;
    logic [LW-1:0]     gain;
    logic [LW:0]       sum;
    logic [LW-1:0]     refilled;
    logic [LW-1:0]     lvl_pre;
    logic [MW-1:0]     stamp_pre;
    logic              checks_pass;

    cal_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_op     (i_s_tdata[1:0]),
        .i_now_ms (i_s_tdata[2 +: MW]),
        .o_valid  (fe_valid),
        .i_ready  (out_free),
        .o_event  (fe_event)
    );

    assign out_free = ~r_ov | i_m_tready;
    assign mv       = fe_valid & out_free;

    // capacity for a rate being written
    assign cfg_cap = LW'(i_cfg_data) * LW'(cal_pkg::UNITS_PER_TOKEN);

    // bucket refill
    assign elapsed  = fe_event.now_ms - r_stamp;
    assign el_clip  = (elapsed > MW'(cal_pkg::UNITS_PER_TOKEN)) ?
                      cal_pkg::UNITS_PER_TOKEN : elapsed[15:0];
    assign gain     = LW'(el_clip) * LW'(r_rate);
    assign sum      = {1'b0, r_level} + {1'b0, gain};
    assign refilled = (sum > {1'b0, r_cap}) ? r_cap : sum[LW-1:0];

    always_comb begin
        if (r_stamp == '0) begin
            lvl_pre   = r_cap;
            stamp_pre = fe_event.now_ms;
        end else if (fe_event.now_ms > r_stamp) begin
            lvl_pre   = refilled;
            stamp_pre = fe_event.now_ms;
        end else begin
            lvl_pre   = r_level;
            stamp_pre = r_stamp;
        end
    end

    // event update
    always_comb begin
        n_open      = r_open;
        n_acc       = r_acc;
        n_cap_rej   = r_cap_rej;
        n_rate_rej  = r_rate_rej;
        n_last_s    = r_last_s;
        n_level     = r_level;
        n_stamp     = r_stamp;
        n_status    = cal_pkg::ST_OK;
        checks_pass = 1'b0;

        // enable, cap and bucket checks
        if (fe_event.op == cal_pkg::OP_TRY_ACCEPT ||
            fe_event.op == cal_pkg::OP_CHECK_ONLY) begin
            if (!r_enable) begin
                n_status = cal_pkg::ST_INACTIVE;
            end else if (r_max_conc != '0 && r_open >= r_max_conc) begin
                n_status  = cal_pkg::ST_CAP_HIT;
                n_cap_rej = cal_pkg::sat_inc32(r_cap_rej);
            end else if (r_rate != '0) begin
                n_stamp = stamp_pre;
                if (lvl_pre < LW'(cal_pkg::UNITS_PER_TOKEN)) begin
                    n_level    = lvl_pre;
                    n_status   = cal_pkg::ST_RATE_HIT;
                    n_rate_rej = cal_pkg::sat_inc32(r_rate_rej);
                end else begin
                    n_level     = lvl_pre - LW'(cal_pkg::UNITS_PER_TOKEN);
                    checks_pass = 1'b1;
                end
            end else begin
                checks_pass = 1'b1;
            end
        end

        case (fe_event.op)
            cal_pkg::OP_TRY_ACCEPT, cal_pkg::OP_NOTE_ACCEPT: begin
                if (fe_event.op == cal_pkg::OP_NOTE_ACCEPT || checks_pass) begin
                    n_open   = (r_open == {CW{1'b1}}) ? r_open : r_open + 1'b1;
                    n_acc    = cal_pkg::sat_inc32(r_acc);
                    n_last_s = fe_event.now_s;
                end
            end
            cal_pkg::OP_NOTE_CLOSE: begin
                n_open   = (r_open == '0) ? r_open : r_open - 1'b1;
                n_last_s = fe_event.now_s;
            end
            default: begin
                n_open = r_open;
            end
        endcase
    end

    // configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_max_conc <= '0;
            r_rate     <= '0;
            r_cap      <= '0;
            r_open     <= '0;
            r_acc      <= '0;
            r_cap_rej  <= '0;
            r_rate_rej <= '0;
            r_last_s   <= '0;
            r_level    <= '0;
            r_stamp    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cal_pkg::REG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                    end
                    cal_pkg::REG_MAX_CONC: begin
                        r_max_conc <= i_cfg_data;
                    end
                    cal_pkg::REG_RATE: begin
                        r_rate <= i_cfg_data;
                        r_cap  <= cfg_cap;
                        if (r_level > cfg_cap) begin
                            r_level <= cfg_cap;
                        end
                    end
                    default: begin
                        r_enable <= r_enable;
                    end
                endcase
            end
            if (mv) begin
                r_open     <= n_open;
                r_acc      <= n_acc;
                r_cap_rej  <= n_cap_rej;
                r_rate_rej <= n_rate_rej;
                r_last_s   <= n_last_s;
                r_level    <= n_level;
                r_stamp    <= n_stamp;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (mv) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (mv) begin
            r_status  <= n_status;
            o_m_tdata <= {7'd0, n_level, n_last_s, n_rate_rej, n_cap_rej, n_acc,
                          n_open, n_status};
        end
    end

    assign o_m_tvalid = r_ov;

    // bucket stays within its capacity, and is empty with no rate set
    a_level_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rate != '0 |-> r_level <= r_cap)
        else $error("bucket level above capacity");

    a_level_zero_unlimited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rate == '0 |-> r_level == '0)
        else $error("bucket level nonzero with no rate");

    // a rejected check never counts a connection
    a_reject_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv && n_status != cal_pkg::ST_OK |=> r_acc == $past(r_acc) && r_status != cal_pkg::ST_OK)
        else $error("rejected event changed accept count");

    // a finished event always lands in the output register
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv |=> o_m_tvalid)
        else $error("result lost");

endmodule

`default_nettype wire
